### hdl/srm_pkg.sv
`timescale 1ns / 1ps

package srm_pkg;

   // Budget used when the budget register holds zero.
   localparam logic [7:0] DEFAULT_BUDGET = 8'd40;

   // Case folding: upper-case letters move up by this much.
   localparam logic [7:0] FOLD_OFFSET = 8'd32;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

   // Folded letters of the negation word "not".
   localparam logic [7:0] CHAR_N = 8'h6E;
   localparam logic [7:0] CHAR_O = 8'h6F;
   localparam logic [7:0] CHAR_T = 8'h74;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   // Item kinds on the request channel.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_CHAR = 1'b1;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_PATTERN_CHARS = 2'd0,
      REG_PATTERN_LENGTH = 2'd1,
      REG_CHAR_BUDGET = 2'd2
   } reg_index_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_FOUND = 2'd0,
      STATUS_BUDGET = 2'd1,
      STATUS_NEGATED = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   // Values derived from the configuration registers.
   typedef struct packed {
      logic [3:0] eff_len;
      logic has_not;
      logic [7:0] budget;
   } pattern_info_type;

   // One result item.
   typedef struct packed {
      logic found;
      status_type status;
   } result_type;

   // Fold A..Z to a..z, leave every other byte alone.
   function automatic logic [7:0] fold(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + FOLD_OFFSET;
      end
      return r;
   endfunction

endpackage

### hdl/srm_csr_regs.sv
`timescale 1ns / 1ps

module srm_csr_regs #(
   parameter int MAX_PATTERN = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [63:0] csr_data,
   output logic [MAX_PATTERN-1:0][7:0] pat_bytes,
   output srm_pkg::pattern_info_type pat_info
);

   localparam logic [3:0] MAX_LEN = 4'(MAX_PATTERN);

   logic [MAX_PATTERN*8-1:0] pattern_chars_ff;
   logic [3:0] pattern_length_ff;
   logic [7:0] char_budget_ff;
   logic [3:0] sat_len;
   logic [3:0] eff_len;
   logic has_not;

   // Register writes; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_chars_ff <= '0;
         pattern_length_ff <= '0;
         char_budget_ff <= srm_pkg::DEFAULT_BUDGET;
      end else if (csr_we) begin
         if (csr_index == srm_pkg::REG_PATTERN_CHARS) begin
            pattern_chars_ff <= csr_data[MAX_PATTERN*8-1:0];
         end
         if (csr_index == srm_pkg::REG_PATTERN_LENGTH) begin
            pattern_length_ff <= csr_data[3:0];
         end
         if (csr_index == srm_pkg::REG_CHAR_BUDGET) begin
            char_budget_ff <= csr_data[7:0];
         end
      end
   end

   // Folded pattern bytes.
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pat_bytes[i] = srm_pkg::fold(pattern_chars_ff[i*8 +: 8]);
      end
   end

   // Effective length: saturate, then cut at the first zero byte.
   always_comb begin
      sat_len = (pattern_length_ff > MAX_LEN) ? MAX_LEN : pattern_length_ff;
      eff_len = sat_len;
      for (int i = MAX_PATTERN - 1; i >= 0; i--) begin
         if (4'(i) < sat_len && pat_bytes[i] == srm_pkg::CHAR_NUL) begin
            eff_len = 4'(i);
         end
      end
   end

   // Whether the pattern itself contains the negation word.
   always_comb begin
      has_not = 1'b0;
      for (int i = 0; i + 3 <= MAX_PATTERN; i++) begin
         if (4'(i + 3) <= eff_len && pat_bytes[i] == srm_pkg::CHAR_N &&
             pat_bytes[i+1] == srm_pkg::CHAR_O && pat_bytes[i+2] == srm_pkg::CHAR_T) begin
            has_not = 1'b1;
         end
      end
   end

   assign pat_info.eff_len = eff_len;
   assign pat_info.has_not = has_not;
   assign pat_info.budget = (char_budget_ff == '0) ? srm_pkg::DEFAULT_BUDGET : char_budget_ff;

endmodule

### hdl/srm_search.sv
`timescale 1ns / 1ps

module srm_search #(
   parameter int MAX_PATTERN = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic item_valid,
   input  logic item_kind,
   input  logic [7:0] item_char,
   input  logic [MAX_PATTERN-1:0][7:0] pat_bytes,
   input  srm_pkg::pattern_info_type pat_info,
   output logic result_valid,
   output srm_pkg::result_type result
);

   logic search_active_ff, search_active_in;
   logic [3:0] match_position_ff, match_position_in;
   logic [7:0] chars_left_ff, chars_left_in;
   logic [15:0] last_two_chars_ff, last_two_chars_in;
   logic negation_seen_ff, negation_seen_in;
   logic nul_seen_ff, nul_seen_in;

   logic [7:0] c;
   logic [7:0] expected;
   logic [3:0] pos_next;

   // Pattern byte at the current match position.
   always_comb begin
      expected = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (match_position_ff == 4'(i)) begin
            expected = pat_bytes[i];
         end
      end
   end

   assign c = srm_pkg::fold(item_char);
   assign pos_next = match_position_ff + 4'd1;

   // One item: next search state and the result it causes.
   always_comb begin
      search_active_in = search_active_ff;
      match_position_in = match_position_ff;
      chars_left_in = chars_left_ff;
      last_two_chars_in = last_two_chars_ff;
      negation_seen_in = negation_seen_ff;
      nul_seen_in = nul_seen_ff;
      result_valid = 1'b0;
      result.found = 1'b0;
      result.status = srm_pkg::STATUS_EMPTY;
      if (item_valid) begin
         if (item_kind == srm_pkg::KIND_START) begin
            if (pat_info.eff_len == '0) begin
               search_active_in = 1'b0;
               result_valid = 1'b1;
               result.status = srm_pkg::STATUS_EMPTY;
            end else begin
               search_active_in = 1'b1;
               match_position_in = '0;
               chars_left_in = pat_info.budget;
               last_two_chars_in = '0;
               negation_seen_in = 1'b0;
               nul_seen_in = 1'b0;
            end
         end else if (search_active_ff) begin
            // Negation word detection stops at the first NUL byte.
            nul_seen_in = nul_seen_ff || (c == srm_pkg::CHAR_NUL);
            if (!nul_seen_in) begin
               if (last_two_chars_ff == {srm_pkg::CHAR_N, srm_pkg::CHAR_O} &&
                   c == srm_pkg::CHAR_T) begin
                  negation_seen_in = 1'b1;
               end
               last_two_chars_in = {last_two_chars_ff[7:0], c};
            end
            if (chars_left_ff != '0) begin
               chars_left_in = chars_left_ff - 8'd1;
            end
            // A mismatch restarts the match without looking at this byte again.
            if (match_position_ff < pat_info.eff_len && c == expected) begin
               match_position_in = pos_next;
            end else begin
               match_position_in = '0;
            end
            if (match_position_ff < pat_info.eff_len && c == expected &&
                pos_next == pat_info.eff_len) begin
               search_active_in = 1'b0;
               result_valid = 1'b1;
               if (negation_seen_in && !pat_info.has_not) begin
                  result.status = srm_pkg::STATUS_NEGATED;
               end else begin
                  result.found = 1'b1;
                  result.status = srm_pkg::STATUS_FOUND;
               end
            end else if (chars_left_in == '0) begin
               search_active_in = 1'b0;
               result_valid = 1'b1;
               result.status = srm_pkg::STATUS_BUDGET;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_active_ff <= 1'b0;
         match_position_ff <= '0;
         chars_left_ff <= '0;
         last_two_chars_ff <= '0;
         negation_seen_ff <= 1'b0;
         nul_seen_ff <= 1'b0;
      end else begin
         search_active_ff <= search_active_in;
         match_position_ff <= match_position_in;
         chars_left_ff <= chars_left_in;
         last_two_chars_ff <= last_two_chars_in;
         negation_seen_ff <= negation_seen_in;
         nul_seen_ff <= nul_seen_in;
      end
   end

`ifndef NO_ASSERTIONS
   // A running search always has a partial match shorter than the pattern.
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      search_active_ff |-> match_position_ff < pat_info.eff_len)
      else $error("match position out of range during search");

   // A running search always has budget left.
   a_budget_left: assert property (@(posedge clock) disable iff (reset)
      search_active_ff |-> chars_left_ff != '0)
      else $error("search active with no budget left");

   // The empty-pattern status comes only from a start with an empty pattern.
   a_empty_only_on_start: assert property (@(posedge clock) disable iff (reset)
      (result_valid && result.status == srm_pkg::STATUS_EMPTY) |->
         (item_kind == srm_pkg::KIND_START && pat_info.eff_len == '0))
      else $error("empty status without an empty pattern");
`endif

endmodule

### hdl/serial_response_matcher_unit.sv
`timescale 1ns / 1ps

// Serial response matcher. A start item (tuser 0) arms a search for the configured
// pattern, compared without regard to letter case; each character item (tuser 1)
// is checked against the next pattern character, and a search ends with one
// result: found, budget exhausted, negated (the received text held "not" before
// any NUL byte while the pattern does not) or empty pattern (at once on start).
// One item is accepted per cycle unless the response register is full and stalled;
// the result of an item is registered in a single-stage input register, passed
// through the search logic and registered in the response register. Configuration
// is always accepted and must only be written while no search is running.
module serial_response_matcher_unit #(
   parameter int MAX_PATTERN = 8
) (
   input  logic clock,
   input  logic reset,
   // Request channel.
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,  // [7:0] rx_char
   input  logic req_tuser,        // [0] kind
   // Response channel.
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,  // [0] found, [7:1] zero
   output logic [1:0] rsp_tuser,  // [1:0] status
   // Configuration write channel.
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [63:0] csr_data
);

   logic in_valid_ff;
   logic in_kind_ff;
   logic [7:0] in_char_ff;
   logic rsp_valid_ff;
   srm_pkg::result_type rsp_ff;

   logic rsp_free;
   logic process;
   logic res_valid;
   srm_pkg::result_type res;
   logic [MAX_PATTERN-1:0][7:0] pat_bytes;
   srm_pkg::pattern_info_type pat_info;

   // An item is processed when the response register can take its result.
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign process = in_valid_ff && rsp_free;
   assign req_tready = !in_valid_ff || process;
   assign csr_ready = 1'b1;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_tuser;
         in_char_ff <= req_tdata;
      end
   end

   srm_csr_regs #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_csr_regs (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .pat_bytes(pat_bytes),
      .pat_info(pat_info)
   );

   srm_search #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_search (
      .clock(clock),
      .reset(reset),
      .item_valid(process),
      .item_kind(in_kind_ff),
      .item_char(in_char_ff),
      .pat_bytes(pat_bytes),
      .pat_info(pat_info),
      .result_valid(res_valid),
      .result(res)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= process && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (process && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, rsp_ff.found};
   assign rsp_tuser = rsp_ff.status;

`ifndef NO_ASSERTIONS
   // The found flag agrees with the status code.
   a_found_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.found == (rsp_ff.status == srm_pkg::STATUS_FOUND)))
      else $error("found flag disagrees with status");

   // A buffered item that cannot be processed stays buffered.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !process) |=> in_valid_ff && $stable(in_char_ff))
      else $error("input item lost while stalled");

   // A result is only written into a free response register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (process && res_valid) |-> rsp_free)
      else $error("response overwritten before transfer");
`endif

endmodule

### bench/tb_serial_response_matcher_unit.sv
`timescale 1ns / 1ps

module tb_serial_response_matcher_unit;
   import srm_pkg::*;

   localparam int PAT_MAX = 8;
   localparam int ITEM_TARGET = 2000;
   localparam int QUIET_AFTER = 1700;
   localparam int HOLD_AFTER = 800;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_STARTS = 40;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_LIMIT = 20000;

   // One row of the directed table.
   typedef enum logic [1:0] {ROW_CONFIG, ROW_START, ROW_CHAR} row_op_type;
   typedef struct packed {
      row_op_type op;
      logic [63:0] chars;
      logic [3:0] len;
      logic [7:0] budget;
      logic [7:0] ch;
      logic fixed;
      status_type st;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'd0;   // [7:0] rx_char
   logic req_tuser = KIND_START;   // [0] kind
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [0] found, [7:1] zero
   logic [1:0] rsp_tuser;          // [1:0] status
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = REG_PATTERN_CHARS;
   logic [63:0] csr_data = 64'd0;

   // Configuration as the bench has written it.
   logic [63:0] cfg_chars = 64'd0;
   logic [3:0] cfg_len = 4'd0;
   logic [7:0] cfg_budget = DEFAULT_BUDGET;

   // Search state of the matcher as the bench predicts it.
   logic srch_active = 1'b0;
   logic [3:0] match_pos = 4'd0;
   logic [7:0] chars_left = 8'd0;
   logic [15:0] tail_chars = 16'd0;
   logic neg_seen = 1'b0;
   logic nul_hit = 1'b0;

   result_type reply_q[$];
   stim_row_type dir_rows[$];
   int err_count = 0;
   int item_count = 0;
   bit quiet = 1'b0;
   bit hold_req = 1'b0;

   serial_response_matcher_unit #(
      .MAX_PATTERN(PAT_MAX)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The run ends here if the matcher hangs.
   initial begin
      #20_000_000;
      $display("tb_serial_response_matcher_unit NOT OK");
      $finish;
   end

   // Only upper-case letters change when folded.
   function automatic logic [7:0] lower_case(input logic [7:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return c + FOLD_OFFSET;
      end
      return c;
   endfunction

   function automatic logic [7:0] pattern_char(input int i);
      return lower_case(cfg_chars[i*8 +: 8]);
   endfunction

   // Pattern length after saturation and the cut at the first zero byte.
   function automatic int live_length();
      int n;
      n = (cfg_len > PAT_MAX) ? PAT_MAX : int'(cfg_len);
      for (int i = 0; i < n; i++) begin
         if (pattern_char(i) == CHAR_NUL) begin
            return i;
         end
      end
      return n;
   endfunction

   function automatic bit pattern_says_not(input int n);
      for (int i = 0; i + 3 <= n; i++) begin
         if (pattern_char(i) == CHAR_N && pattern_char(i + 1) == CHAR_O &&
             pattern_char(i + 2) == CHAR_T) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Advances the predicted search by one accepted request and tells whether
   // it ends with a reply.
   function automatic void predict_reply(input logic kind, input logic [7:0] raw,
                                         output bit got, output result_type res);
      logic [7:0] c;
      int n;
      c = lower_case(raw);
      n = live_length();
      got = 1'b0;
      res = '0;
      if (kind == KIND_START) begin
         if (n == 0) begin
            srch_active = 1'b0;
            got = 1'b1;
            res.found = 1'b0;
            res.status = STATUS_EMPTY;
            return;
         end
         srch_active = 1'b1;
         match_pos = 4'd0;
         chars_left = (cfg_budget == 8'd0) ? DEFAULT_BUDGET : cfg_budget;
         tail_chars = 16'd0;
         neg_seen = 1'b0;
         nul_hit = 1'b0;
         return;
      end
      if (!srch_active) begin
         return;
      end
      // The negation word is only looked for before the first NUL byte.
      if (c == CHAR_NUL) begin
         nul_hit = 1'b1;
      end
      if (!nul_hit) begin
         if (tail_chars == {CHAR_N, CHAR_O} && c == CHAR_T) begin
            neg_seen = 1'b1;
         end
         tail_chars = {tail_chars[7:0], c};
      end
      if (chars_left != 8'd0) begin
         chars_left = chars_left - 8'd1;
      end
      if (int'(match_pos) < n && c == pattern_char(int'(match_pos))) begin
         match_pos = match_pos + 4'd1;
         if (int'(match_pos) == n) begin
            srch_active = 1'b0;
            got = 1'b1;
            if (neg_seen && !pattern_says_not(n)) begin
               res.found = 1'b0;
               res.status = STATUS_NEGATED;
            end else begin
               res.found = 1'b1;
               res.status = STATUS_FOUND;
            end
            return;
         end
      end else begin
         match_pos = 4'd0;
      end
      if (chars_left == 8'd0) begin
         srch_active = 1'b0;
         got = 1'b1;
         res.found = 1'b0;
         res.status = STATUS_BUDGET;
      end
   endfunction

   // Offers one request, waits for its transfer, records the expected reply
   // and sometimes leaves a gap afterwards.
   task automatic send_req(input logic kind, input logic [7:0] ch,
                           input bit use_fixed = 1'b0,
                           input status_type fixed_st = STATUS_FOUND);
      bit got;
      bit counted;
      result_type res;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      counted = (kind == KIND_START) || srch_active;
      predict_reply(kind, ch, got, res);
      if (got) begin
         if (use_fixed) begin
            res.found = (fixed_st == STATUS_FOUND);
            res.status = fixed_st;
         end
         reply_q.push_back(res);
      end
      if (counted) begin
         item_count++;
      end
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_PATTERN_CHARS: cfg_chars = data;
         REG_PATTERN_LENGTH: cfg_len = data[3:0];
         REG_CHAR_BUDGET: cfg_budget = data[7:0];
         default: ;
      endcase
   endtask

   task automatic write_config(input logic [63:0] chars, input logic [63:0] len,
                               input logic [63:0] budget);
      write_reg(REG_PATTERN_CHARS, chars);
      write_reg(REG_PATTERN_LENGTH, len);
      write_reg(REG_CHAR_BUDGET, budget);
      csr_valid <= 1'b0;
   endtask

   // Brings the matcher to rest: a running search is run out with NUL bytes,
   // which never match, and every reply is collected.
   task automatic settle();
      while (srch_active) send_req(KIND_CHAR, CHAR_NUL);
      req_tvalid <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] random_case(input logic [7:0] c);
      logic [7:0] l;
      l = lower_case(c);
      if (l >= 8'h61 && l <= 8'h7A && $urandom_range(0, 1) == 1) begin
         return l - FOLD_OFFSET;
      end
      return l;
   endfunction

   function automatic logic [7:0] pattern_pick();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0: c = CHAR_N;
         1: c = CHAR_O;
         2: c = CHAR_T;
         3: c = 8'h6B;
         4: c = 8'h61;
         5: c = 8'h7A;
         6: c = 8'($urandom_range(1, 255));
         7: c = ($urandom_range(0, 3) == 0) ? CHAR_NUL : 8'h40;
         default: c = 8'h72;
      endcase
      return random_case(c);
   endfunction

   // Bytes that mostly miss the pattern, with the case boundaries and NUL.
   function automatic logic [7:0] noise_char();
      case ($urandom_range(0, 15))
         0: return CHAR_NUL;
         1, 2, 3: return 8'($urandom_range(0, 255));
         4: return 8'h40;
         5: return 8'h5B;
         6: return CHAR_UPPER_A;
         7: return CHAR_UPPER_Z;
         8: return random_case(CHAR_N);
         9: return random_case(CHAR_O);
         default: return random_case(pattern_char($urandom_range(0, 7)));
      endcase
   endfunction

   // One start followed by an optional negation word, noise and often the
   // whole pattern in mixed case.
   task automatic random_search();
      int n;
      n = live_length();
      send_req(KIND_START, 8'($urandom_range(0, 255)));
      if (srch_active && $urandom_range(0, 2) == 0) begin
         for (int i = 0; i < 3; i++) begin
            if (srch_active) begin
               send_req(KIND_CHAR, random_case(i == 0 ? CHAR_N : (i == 1 ? CHAR_O : CHAR_T)));
            end
         end
      end
      repeat ($urandom_range(0, 6)) begin
         if (srch_active) send_req(KIND_CHAR, noise_char());
      end
      if ($urandom_range(0, 3) != 0) begin
         for (int i = 0; i < n; i++) begin
            if (srch_active) send_req(KIND_CHAR, random_case(pattern_char(i)));
         end
      end
      // A stray byte, often to an idle matcher.
      if ($urandom_range(0, 7) == 0) begin
         send_req(KIND_CHAR, noise_char());
      end
   endtask

   task automatic random_phase();
      logic [63:0] chars;
      logic [63:0] len_w;
      logic [63:0] bud_w;
      int plen;
      int stop_at;
      settle();
      plen = $urandom_range(1, 8);
      chars = '0;
      case ($urandom_range(0, 9))
         0: chars = {$urandom, $urandom};
         1: chars = '1;
         2: begin
            chars = 64'h0000_006B_6F74_6F6E;
            plen = 5;
         end
         default: begin
            for (int i = 0; i < plen; i++) chars[i*8 +: 8] = pattern_pick();
         end
      endcase
      case ($urandom_range(0, 9))
         0: len_w = 64'd0;
         1: len_w = 64'd15;
         2: len_w = {$urandom, $urandom};
         3: len_w = 64'd8;
         default: len_w = 64'(plen);
      endcase
      case ($urandom_range(0, 9))
         0: bud_w = 64'd0;
         1: bud_w = 64'd1;
         2: bud_w = 64'd255;
         3: bud_w = {$urandom, $urandom};
         default: bud_w = 64'($urandom_range(plen + 4, 80));
      endcase
      write_config(chars, len_w, bud_w);
      stop_at = item_count + $urandom_range(40, 120);
      while (item_count < stop_at) random_search();
   endtask

   function automatic void row_cfg(input logic [63:0] chars, input logic [3:0] len,
                                   input logic [7:0] budget);
      stim_row_type r;
      r = '0;
      r.op = ROW_CONFIG;
      r.chars = chars;
      r.len = len;
      r.budget = budget;
      dir_rows.push_back(r);
   endfunction

   function automatic void row_item(input row_op_type op, input logic [7:0] ch,
                                    input bit fixed = 1'b0,
                                    input status_type st = STATUS_FOUND);
      stim_row_type r;
      r = '0;
      r.op = op;
      r.ch = ch;
      r.fixed = fixed;
      r.st = st;
      dir_rows.push_back(r);
   endfunction

   // Receiver side: random stalls, one long hold-off on request, none at the end.
   initial begin
      @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // Each reply transfer is compared with the oldest expected reply.
   always @(posedge clock) begin : check_replies
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (reply_q.size() == 0) begin
            if (err_count < 10) begin
               $display("unexpected reply: found=%0d status=%0d", rsp_tdata[0], rsp_tuser);
            end
            err_count++;
         end else begin
            want = reply_q.pop_front();
            if (rsp_tdata[0] !== want.found || rsp_tuser !== want.status) begin
               if (err_count < 10) begin
                  $display("reply mismatch: expected found=%0d status=%0d, got found=%0d status=%0d",
                           want.found, want.status, rsp_tdata[0], rsp_tuser);
               end
               err_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int waited;
      bit hold_done;
      stim_row_type r;
      hold_done = 1'b0;

      // Directed table: empty pattern after reset, restart mid-search,
      // negation, budget ending on the matching byte, NUL and length cut.
      row_item(ROW_START, 8'h00, 1'b1, STATUS_EMPTY);
      row_cfg(64'h6B4F, 4'd2, 8'd0);
      row_item(ROW_START, 8'hFF);
      row_item(ROW_CHAR, 8'h6F);
      row_item(ROW_START, 8'h00);
      row_item(ROW_CHAR, 8'h6F);
      row_item(ROW_CHAR, 8'h4B);
      row_item(ROW_START, 8'h00);
      row_item(ROW_CHAR, 8'h6E);
      row_item(ROW_CHAR, 8'h4F);
      row_item(ROW_CHAR, 8'h74);
      row_item(ROW_CHAR, 8'h6F);
      row_item(ROW_CHAR, 8'h6B);
      row_cfg(64'h74_6F6E, 4'd3, 8'd2);
      row_item(ROW_START, 8'h00);
      row_item(ROW_CHAR, 8'h78);
      row_item(ROW_CHAR, 8'h40, 1'b1, STATUS_BUDGET);
      row_item(ROW_START, 8'h00);
      row_item(ROW_CHAR, 8'h4E);
      row_item(ROW_CHAR, 8'h4F);
      row_item(ROW_CHAR, 8'h54);
      row_cfg(64'h4142_4344_0063_6261, 4'd15, 8'd255);
      row_item(ROW_START, 8'h00);
      row_item(ROW_CHAR, 8'h00);
      row_item(ROW_CHAR, 8'h6E);
      row_item(ROW_CHAR, 8'h6F);
      row_item(ROW_CHAR, 8'h74);
      row_item(ROW_CHAR, 8'h41);
      row_item(ROW_CHAR, 8'h62);
      row_item(ROW_CHAR, 8'h43);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         r = dir_rows[i];
         case (r.op)
            ROW_CONFIG: begin
               settle();
               write_config(r.chars, 64'(r.len), 64'(r.budget));
            end
            ROW_START: send_req(KIND_START, r.ch, r.fixed, r.st);
            default: send_req(KIND_CHAR, r.ch, r.fixed, r.st);
         endcase
      end

      // Random phases, each with its own configuration.
      item_count = 0;
      while (item_count < ITEM_TARGET) begin
         if (!hold_done && item_count > HOLD_AFTER) begin
            // Empty pattern: every start yields a reply while the receiver
            // holds off, so the matcher fills up and stalls its input.
            settle();
            write_config(64'd0, 64'd0, 64'd0);
            hold_req = 1'b1;
            repeat (HOLD_STARTS) send_req(KIND_START, 8'($urandom_range(0, 255)));
            hold_done = 1'b1;
         end
         random_phase();
         quiet = (item_count > QUIET_AFTER);
      end

      // Collect the last replies, then watch for stray ones.
      req_tvalid <= 1'b0;
      waited = 0;
      while (reply_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (err_count == 0 && reply_q.size() == 0) begin
         $display("tb_serial_response_matcher_unit OK");
      end else begin
         $display("tb_serial_response_matcher_unit NOT OK");
      end
      $finish;
   end

endmodule
